/* rtl/bric_pkg.sv */
// Package for the blind relay interlock controller: payload types, codes and relay lookup.
package bric_pkg;

	// Input item codes
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_CMD  = 1'b1;

	localparam logic [1:0] CMD_UP      = 2'd0;
	localparam logic [1:0] CMD_STOP    = 2'd1;
	localparam logic [1:0] CMD_DOWN    = 2'd2;
	localparam logic [1:0] CMD_INVALID = 2'd3;

	// Reported motion codes
	localparam logic [1:0] MC_STOP    = 2'd0;
	localparam logic [1:0] MC_PREPARE = 2'd1;
	localparam logic [1:0] MC_UP      = 2'd2;
	localparam logic [1:0] MC_DOWN    = 2'd3;

	// Requested motion codes
	localparam logic [1:0] REQ_STOP = 2'd0;
	localparam logic [1:0] REQ_UP   = 2'd2;
	localparam logic [1:0] REQ_DOWN = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_IDX_MODE      = 3'd0;
	localparam logic [2:0] CFG_IDX_STOP_WAIT = 3'd1;
	localparam logic [2:0] CFG_IDX_PREP_WAIT = 3'd2;
	localparam logic [2:0] CFG_IDX_UP_LIMIT  = 3'd3;
	localparam logic [2:0] CFG_IDX_DN_LIMIT  = 3'd4;

	// Configuration reset values
	localparam logic [2:0]  RST_MODE      = 3'd0;
	localparam logic [15:0] RST_STOP_WAIT = 16'd100;
	localparam logic [15:0] RST_PREP_WAIT = 16'd900;
	localparam logic [15:0] RST_UP_LIMIT  = 16'd60000;
	localparam logic [15:0] RST_DN_LIMIT  = 16'd60000;

	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	// Wiring modes
	localparam logic [2:0] MODE_A_PWR_B_UP = 3'd0;
	localparam logic [2:0] MODE_A_PWR_B_DN = 3'd1;
	localparam logic [2:0] MODE_A_UP_B_PWR = 3'd2;
	localparam logic [2:0] MODE_A_DN_B_PWR = 3'd3;
	localparam logic [2:0] MODE_A_UP_B_DN  = 3'd4;
	localparam logic [2:0] MODE_A_DN_B_UP  = 3'd5;

	typedef struct packed {
		logic       action;
		logic [1:0] command_code;
	} in_item_t;

	typedef struct packed {
		logic       status;
		logic [1:0] motion_code;
		logic       relay_a_on;
		logic       relay_b_on;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  interlock_mode;
		logic [15:0] stop_wait_ms;
		logic [15:0] prepare_wait_ms;
		logic [15:0] up_limit_ms;
		logic [15:0] down_limit_ms;
	} cfg_t;

	typedef enum logic [4:0] {
		MS_STOP      = 5'b00001,
		MS_PREP_UP   = 5'b00010,
		MS_UP        = 5'b00100,
		MS_DOWN      = 5'b01000,
		MS_PREP_DOWN = 5'b10000
	} motion_t;

	// Relay drives for a wiring mode and motion state: bit 0 relay A, bit 1 relay B
	function automatic logic [1:0] relay_drive(input logic [2:0] mode, input motion_t st);
		logic [1:0] r;
		r = 2'b00;
		case (st)
			MS_PREP_UP: begin
				case (mode)
					MODE_A_PWR_B_UP: r = 2'b10;
					MODE_A_UP_B_PWR: r = 2'b01;
					default:         r = 2'b00;
				endcase
			end
			MS_PREP_DOWN: begin
				case (mode)
					MODE_A_PWR_B_DN: r = 2'b10;
					MODE_A_DN_B_PWR: r = 2'b01;
					default:         r = 2'b00;
				endcase
			end
			MS_UP: begin
				case (mode)
					MODE_A_PWR_B_UP: r = 2'b11;
					MODE_A_PWR_B_DN: r = 2'b01;
					MODE_A_UP_B_PWR: r = 2'b11;
					MODE_A_DN_B_PWR: r = 2'b10;
					MODE_A_UP_B_DN:  r = 2'b01;
					MODE_A_DN_B_UP:  r = 2'b10;
					default:         r = 2'b00;
				endcase
			end
			MS_DOWN: begin
				case (mode)
					MODE_A_PWR_B_UP: r = 2'b01;
					MODE_A_PWR_B_DN: r = 2'b11;
					MODE_A_UP_B_PWR: r = 2'b10;
					MODE_A_DN_B_PWR: r = 2'b11;
					MODE_A_UP_B_DN:  r = 2'b10;
					MODE_A_DN_B_UP:  r = 2'b01;
					default:         r = 2'b00;
				endcase
			end
			default: r = 2'b00;
		endcase
		return r;
	endfunction

	// Reported code for a motion state
	function automatic logic [1:0] motion_code_of(input motion_t st);
		logic [1:0] c;
		case (st)
			MS_PREP_UP, MS_PREP_DOWN: c = MC_PREPARE;
			MS_UP:                    c = MC_UP;
			MS_DOWN:                  c = MC_DOWN;
			default:                  c = MC_STOP;
		endcase
		return c;
	endfunction

endpackage

/* rtl/blind_relay_interlock_controller_core.sv */
// Top level of the blind relay interlock controller: input register, state machine, result register.
//
// Channel | Signals                                  | Direction | Payload
// input   | in_valid, in_stall, in_data              | in        | in_item_t
// result  | out_valid, out_stall, out_data           | out       | out_item_t
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | index 3 bits, data 16 bits
//
// One item per cycle sustained while the result is not stalled.
// An item sits in the input register, passes the state update and lands in the result register.
// A stalled result holds the result register; the input register then holds one more item.
// Reset clears the state machine to stop, the registers to their defaults and both stages to empty.
// Configuration writes are always ready and take effect on the next cycle.
module blind_relay_interlock_controller_core
	import bric_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t result_q;
	logic      out_valid_q;
	logic      advance;
	logic      step;

	assign cfg_ready = 1'b1;

	bric_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Stage 1 moves on when the result register is empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	bric_motion_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = result_q;

	// Stop state never drives a relay
	a_stop_relays_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.motion_code == MC_STOP) |->
			(!out_data.relay_a_on && !out_data.relay_b_on))
		else $error("relay driven in stop state");

	// An invalid command processed yields a rejected status
	a_invalid_status: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.action == ACT_CMD && item_s1.command_code == CMD_INVALID) |=>
			(out_valid && out_data.status))
		else $error("invalid command not reported");

	// Input stalls only behind a stalled, full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && valid_s1))
		else $error("input stalled without a blocked result");

	// A tick never reports a rejected status
	a_tick_status: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.action == ACT_TICK) |=> !out_data.status)
		else $error("tick reported rejected status");

endmodule

/* rtl/bric_cfg_regs.sv */
// Configuration register file of the blind relay interlock controller.
module bric_cfg_regs
	import bric_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interlock_mode  <= RST_MODE;
			cfg_q.stop_wait_ms    <= RST_STOP_WAIT;
			cfg_q.prepare_wait_ms <= RST_PREP_WAIT;
			cfg_q.up_limit_ms     <= RST_UP_LIMIT;
			cfg_q.down_limit_ms   <= RST_DN_LIMIT;
		end else if (wr_en) begin
			case (wr_index)
				CFG_IDX_MODE:      cfg_q.interlock_mode  <= wr_data[2:0];
				CFG_IDX_STOP_WAIT: cfg_q.stop_wait_ms    <= wr_data;
				CFG_IDX_PREP_WAIT: cfg_q.prepare_wait_ms <= wr_data;
				CFG_IDX_UP_LIMIT:  cfg_q.up_limit_ms     <= wr_data;
				CFG_IDX_DN_LIMIT:  cfg_q.down_limit_ms   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/bric_motion_fsm.sv */
// Motion state machine: request, elapsed counter, state update and result forming.
module bric_motion_fsm
	import bric_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	motion_t     state_q, state_d;
	logic [1:0]  req_q, req_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [15:0] elapsed_inc;
	logic [1:0]  req_tick;
	logic        status;
	logic [1:0]  relays;

	// Next state for one tick or command
	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		elapsed_d   = elapsed_q;
		status      = 1'b0;
		elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 16'd1 : elapsed_q;
		req_tick    = req_q;
		if ((state_q == MS_UP && elapsed_inc >= cfg.up_limit_ms) ||
		    (state_q == MS_DOWN && elapsed_inc >= cfg.down_limit_ms)) begin
			req_tick = REQ_STOP;
		end
		if (step) begin
			if (item.action == ACT_TICK) begin
				req_d     = req_tick;
				elapsed_d = elapsed_inc;
				case (state_q)
					MS_STOP: begin
						if (req_tick != REQ_STOP && elapsed_inc >= cfg.stop_wait_ms) begin
							state_d   = (req_tick == REQ_UP) ? MS_PREP_UP : MS_PREP_DOWN;
							elapsed_d = '0;
						end
					end
					MS_PREP_UP: begin
						if (req_tick != REQ_UP) begin
							state_d   = MS_STOP;
							elapsed_d = '0;
						end else if (elapsed_inc >= cfg.prepare_wait_ms) begin
							state_d   = MS_UP;
							elapsed_d = '0;
						end
					end
					MS_PREP_DOWN: begin
						if (req_tick != REQ_DOWN) begin
							state_d   = MS_STOP;
							elapsed_d = '0;
						end else if (elapsed_inc >= cfg.prepare_wait_ms) begin
							state_d   = MS_DOWN;
							elapsed_d = '0;
						end
					end
					MS_UP: begin
						if (req_tick != REQ_UP) begin
							state_d   = MS_STOP;
							elapsed_d = '0;
						end
					end
					MS_DOWN: begin
						if (req_tick != REQ_DOWN) begin
							state_d   = MS_STOP;
							elapsed_d = '0;
						end
					end
					default: begin
						state_d   = MS_STOP;
						elapsed_d = '0;
					end
				endcase
			end else begin
				case (item.command_code)
					CMD_UP:   req_d = REQ_UP;
					CMD_STOP: req_d = REQ_STOP;
					CMD_DOWN: req_d = REQ_DOWN;
					default:  status = 1'b1;
				endcase
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= MS_STOP;
			req_q     <= REQ_STOP;
			elapsed_q <= '0;
		end else begin
			state_q   <= state_d;
			req_q     <= req_d;
			elapsed_q <= elapsed_d;
		end
	end

	// Result from the updated state
	assign relays             = relay_drive(cfg.interlock_mode, state_d);
	assign result.status      = status;
	assign result.motion_code = motion_code_of(state_d);
	assign result.relay_a_on  = relays[0];
	assign result.relay_b_on  = relays[1];

endmodule
